>>> design/rpc_pkg.sv
// rpc_pkg: widths, register indexes, vertex payload type and arctangent table
// shared by the point rotation pipeline. No dependencies.
`default_nettype none
package rpc_pkg;

	localparam int COORD_W = 32;
	localparam int ANGLE_W = 16;
	localparam int TAG_W   = 8;
	localparam int IDX_W   = 2;
	localparam int CW      = 34;               // CORDIC datapath width
	localparam int DIFF_W  = COORD_W + 1;      // coordinate minus center
	localparam int TRIG_W  = 32;               // clamped cos/sin, Q30
	localparam int PROD_W  = DIFF_W + TRIG_W;  // full product
	localparam int RND_W   = PROD_W - 30;      // product rounded to Q16.16
	localparam int SUM_W   = RND_W + 2;

	localparam logic [IDX_W-1:0] REG_CENTER_FIRST  = 2'd0;
	localparam logic [IDX_W-1:0] REG_CENTER_SECOND = 2'd1;
	localparam logic [IDX_W-1:0] REG_ANGLE         = 2'd2;
	localparam logic [IDX_W-1:0] REG_GROUP         = 2'd3;

	localparam logic signed [CW-1:0] GAIN_Q30 = 34'sd652032874;
	localparam logic signed [CW-1:0] ONE_Q30  = 34'sd1073741824;

	typedef struct packed {
		logic [COORD_W-1:0] a;
		logic [COORD_W-1:0] b;
		logic [DIFF_W-1:0]  da;
		logic [DIFF_W-1:0]  db;
		logic [1:0]         quad;
		logic               hit;
		logic               last;
	} vtx_t;

	// arctan(2^-i) in units of 2^-32 turn
	function automatic logic [CW-1:0] atan_turn(input logic [4:0] i);
		logic [CW-1:0] v;
		case (i)
			5'd0:  v = 34'd536870912;
			5'd1:  v = 34'd316933406;
			5'd2:  v = 34'd167458907;
			5'd3:  v = 34'd85004756;
			5'd4:  v = 34'd42667331;
			5'd5:  v = 34'd21354465;
			5'd6:  v = 34'd10679838;
			5'd7:  v = 34'd5340245;
			5'd8:  v = 34'd2670163;
			5'd9:  v = 34'd1335087;
			5'd10: v = 34'd667544;
			5'd11: v = 34'd333772;
			5'd12: v = 34'd166886;
			5'd13: v = 34'd83443;
			5'd14: v = 34'd41722;
			5'd15: v = 34'd20861;
			5'd16: v = 34'd10430;
			5'd17: v = 34'd5215;
			5'd18: v = 34'd2608;
			5'd19: v = 34'd1304;
			5'd20: v = 34'd652;
			5'd21: v = 34'd326;
			5'd22: v = 34'd163;
			5'd23: v = 34'd81;
			5'd24: v = 34'd41;
			5'd25: v = 34'd20;
			5'd26: v = 34'd10;
			5'd27: v = 34'd5;
			5'd28: v = 34'd3;
			5'd29: v = 34'd1;
			5'd30: v = 34'd1;
			default: v = 34'd0;
		endcase
		return v;
	endfunction

endpackage
`default_nettype wire

>>> design/rpc_cell.sv
// rpc_cell: one CORDIC rotation stage; carries the vertex word alongside.
// Depends on rpc_pkg.
`default_nettype none
module rpc_cell import rpc_pkg::*; #(
	parameter int STAGE = 0
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 en,
	input  wire logic                 vld_i,
	input  wire logic signed [CW-1:0] x_i,
	input  wire logic signed [CW-1:0] y_i,
	input  wire logic signed [CW-1:0] z_i,
	input  wire vtx_t                 vtx_i,
	output logic                      vld_o,
	output logic signed [CW-1:0]      x_o,
	output logic signed [CW-1:0]      y_o,
	output logic signed [CW-1:0]      z_o,
	output vtx_t                      vtx_o
);

	logic signed [CW-1:0] dx, dy, ang;
	logic signed [CW-1:0] x_nx, y_nx, z_nx;
	logic                 vld_s1;
	logic signed [CW-1:0] x_s1, y_s1, z_s1;
	vtx_t                 vtx_s1;

	assign dx  = y_i >>> STAGE;
	assign dy  = x_i >>> STAGE;
	assign ang = $signed(atan_turn(5'(STAGE)));

	always_comb begin
		if (!z_i[CW-1]) begin
			x_nx = x_i - dx;
			y_nx = y_i + dy;
			z_nx = z_i - ang;
		end else begin
			x_nx = x_i + dx;
			y_nx = y_i - dy;
			z_nx = z_i + ang;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (en) begin
			vld_s1 <= vld_i;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			x_s1   <= x_nx;
			y_s1   <= y_nx;
			z_s1   <= z_nx;
			vtx_s1 <= vtx_i;
		end
	end

	assign vld_o = vld_s1;
	assign x_o   = x_s1;
	assign y_o   = y_s1;
	assign z_o   = z_s1;
	assign vtx_o = vtx_s1;

endmodule
`default_nettype wire

>>> design/rpc_mix.sv
// rpc_mix: quadrant mapping, rotation products, rounding, center add and
// saturation; four pipeline stages ending in the output register. Depends on rpc_pkg.
`default_nettype none
module rpc_mix import rpc_pkg::*; (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      en,
	input  wire logic                      vld_i,
	input  wire logic signed [CW-1:0]      x_i,
	input  wire logic signed [CW-1:0]      y_i,
	input  wire vtx_t                      vtx_i,
	input  wire logic signed [COORD_W-1:0] center_first,
	input  wire logic signed [COORD_W-1:0] center_second,
	output logic                           vld_o,
	output logic [COORD_W-1:0]             rot_first,
	output logic [COORD_W-1:0]             rot_second,
	output logic                           rotated,
	output logic                           last
);

	localparam logic signed [PROD_W-1:0] HALF = PROD_W'(536870912);
	localparam logic signed [SUM_W-1:0]  SMAX = SUM_W'(64'sd2147483647);
	localparam logic signed [SUM_W-1:0]  SMIN = SUM_W'(-64'sd2147483648);

	logic signed [CW-1:0]     cx, cy;
	logic signed [TRIG_W-1:0] c_nx, s_nx, cx_t, cy_t;

	logic                     vld_s1, vld_s2, vld_s3, vld_s4;
	logic signed [TRIG_W-1:0] c_s1, s_s1;
	vtx_t                     vtx_s1, vtx_s2, vtx_s3;

	logic signed [DIFF_W-1:0] da, db;
	logic signed [PROD_W-1:0] ac_s2, bs_s2, bc_s2, as_s2;

	logic signed [PROD_W-1:0] ac_r, bs_r, bc_r, as_r;
	logic signed [SUM_W-1:0]  sum1, sum2;
	logic signed [SUM_W-1:0]  s1_s3, s2_s3;

	logic [COORD_W-1:0]       o1_nx, o2_nx;
	logic [COORD_W-1:0]       o1_s4, o2_s4;
	logic                     hit_s4, last_s4;

	// clamp to [-1, 1] in Q30, then map to quadrant
	always_comb begin
		if (x_i > ONE_Q30)       cx = ONE_Q30;
		else if (x_i < -ONE_Q30) cx = -ONE_Q30;
		else                     cx = x_i;
		if (y_i > ONE_Q30)       cy = ONE_Q30;
		else if (y_i < -ONE_Q30) cy = -ONE_Q30;
		else                     cy = y_i;
		cx_t = cx[TRIG_W-1:0];
		cy_t = cy[TRIG_W-1:0];
		case (vtx_i.quad)
			2'd1: begin
				c_nx = -cy_t;
				s_nx = cx_t;
			end
			2'd2: begin
				c_nx = -cx_t;
				s_nx = -cy_t;
			end
			2'd3: begin
				c_nx = cy_t;
				s_nx = -cx_t;
			end
			default: begin
				c_nx = cx_t;
				s_nx = cy_t;
			end
		endcase
	end

	assign da = $signed(vtx_s1.da);
	assign db = $signed(vtx_s1.db);

	// round each product to Q16.16, add center
	always_comb begin
		ac_r = (ac_s2 + HALF) >>> 30;
		bs_r = (bs_s2 + HALF) >>> 30;
		bc_r = (bc_s2 + HALF) >>> 30;
		as_r = (as_s2 + HALF) >>> 30;
		sum1 = SUM_W'($signed(ac_r[RND_W-1:0])) + SUM_W'($signed(bs_r[RND_W-1:0]))
			+ SUM_W'(center_first);
		sum2 = SUM_W'($signed(bc_r[RND_W-1:0])) - SUM_W'($signed(as_r[RND_W-1:0]))
			+ SUM_W'(center_second);
	end

	always_comb begin
		if (!vtx_s3.hit) begin
			o1_nx = vtx_s3.a;
			o2_nx = vtx_s3.b;
		end else begin
			if (s1_s3 > SMAX)      o1_nx = SMAX[COORD_W-1:0];
			else if (s1_s3 < SMIN) o1_nx = SMIN[COORD_W-1:0];
			else                   o1_nx = s1_s3[COORD_W-1:0];
			if (s2_s3 > SMAX)      o2_nx = SMAX[COORD_W-1:0];
			else if (s2_s3 < SMIN) o2_nx = SMIN[COORD_W-1:0];
			else                   o2_nx = s2_s3[COORD_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
		end else if (en) begin
			vld_s1 <= vld_i;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			c_s1    <= c_nx;
			s_s1    <= s_nx;
			vtx_s1  <= vtx_i;
			ac_s2   <= da * c_s1;
			bs_s2   <= db * s_s1;
			bc_s2   <= db * c_s1;
			as_s2   <= da * s_s1;
			vtx_s2  <= vtx_s1;
			s1_s3   <= sum1;
			s2_s3   <= sum2;
			vtx_s3  <= vtx_s2;
			o1_s4   <= o1_nx;
			o2_s4   <= o2_nx;
			hit_s4  <= vtx_s3.hit;
			last_s4 <= vtx_s3.last;
		end
	end

	assign vld_o      = vld_s4;
	assign rot_first  = o1_s4;
	assign rot_second = o2_s4;
	assign rotated    = hit_s4;
	assign last       = last_s4;

endmodule
`default_nettype wire

>>> design/rotate_point_about_center_top.sv
// Rotates vertices of the configured group about the configured center.
// Path from accepted word to output word: input register, CORDIC cells, tail stages.
// Throughput: one word per cycle while not stalled; one row of CORDIC_STAGES cells, four tail stages.
// The whole pipeline holds while the output word is stalled.
// Reset clears valids and config registers (center 0, angle 0, group 0).
`default_nettype none
module rotate_point_about_center_top import rpc_pkg::*; #(
	parameter int CORDIC_STAGES = 16,
	parameter int GROUP_BITS    = 8
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               wr_en,
	input  wire logic [IDX_W-1:0]   wr_index,
	input  wire logic [COORD_W-1:0] wr_data,
	input  wire logic               in_valid,
	output logic                    in_stall,
	input  wire logic [COORD_W-1:0] first_coord,
	input  wire logic [COORD_W-1:0] second_coord,
	input  wire logic [TAG_W-1:0]   vertex_group,
	input  wire logic               last_in,
	output logic                    out_valid,
	input  wire logic               out_stall,
	output logic [COORD_W-1:0]      rotated_first,
	output logic [COORD_W-1:0]      rotated_second,
	output logic                    was_rotated,
	output logic                    last_out
);

	localparam int GW = (GROUP_BITS < TAG_W) ? GROUP_BITS : TAG_W;
	localparam int N  = CORDIC_STAGES;

	logic [COORD_W-1:0] center_first_q, center_second_q;
	logic [ANGLE_W-1:0] angle_q;
	logic [GW-1:0]      group_q;

	logic adv, accept;

	logic                 vld_s1;
	logic signed [CW-1:0] z_s1;
	vtx_t                 vtx_s1;
	vtx_t                 vtx_nx;

	logic                 vld_c [N+1];
	logic signed [CW-1:0] x_c   [N+1];
	logic signed [CW-1:0] y_c   [N+1];
	logic signed [CW-1:0] z_c   [N+1];
	vtx_t                 vtx_c [N+1];

	assign adv      = !out_valid || !out_stall;
	assign in_stall = !adv;
	assign accept   = in_valid && adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			center_first_q  <= '0;
			center_second_q <= '0;
			angle_q         <= '0;
			group_q         <= '0;
		end else if (wr_en) begin
			case (wr_index)
				REG_CENTER_FIRST:  center_first_q  <= wr_data;
				REG_CENTER_SECOND: center_second_q <= wr_data;
				REG_ANGLE:         angle_q         <= wr_data[ANGLE_W-1:0];
				REG_GROUP:         group_q         <= wr_data[GW-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		vtx_nx.a    = first_coord;
		vtx_nx.b    = second_coord;
		vtx_nx.da   = {first_coord[COORD_W-1], first_coord}
			- {center_first_q[COORD_W-1], center_first_q};
		vtx_nx.db   = {second_coord[COORD_W-1], second_coord}
			- {center_second_q[COORD_W-1], center_second_q};
		vtx_nx.quad = angle_q[ANGLE_W-1 -: 2];
		vtx_nx.hit  = (vertex_group[GW-1:0] == group_q);
		vtx_nx.last = last_in;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (adv) begin
			vld_s1 <= accept;
		end
	end

	// residual angle within the quadrant, scaled to a 32-bit turn
	always_ff @(posedge clk) begin
		if (accept) begin
			z_s1   <= CW'({angle_q[ANGLE_W-3:0], 16'd0});
			vtx_s1 <= vtx_nx;
		end
	end

	assign vld_c[0] = vld_s1;
	assign x_c[0]   = GAIN_Q30;
	assign y_c[0]   = '0;
	assign z_c[0]   = z_s1;
	assign vtx_c[0] = vtx_s1;

	for (genvar i = 0; i < N; i++) begin : g_cell
		rpc_cell #(.STAGE(i)) u_cell (
			.clk   (clk),
			.arst_n(arst_n),
			.en    (adv),
			.vld_i (vld_c[i]),
			.x_i   (x_c[i]),
			.y_i   (y_c[i]),
			.z_i   (z_c[i]),
			.vtx_i (vtx_c[i]),
			.vld_o (vld_c[i+1]),
			.x_o   (x_c[i+1]),
			.y_o   (y_c[i+1]),
			.z_o   (z_c[i+1]),
			.vtx_o (vtx_c[i+1])
		);
	end

	logic unused_z;
	assign unused_z = ^z_c[N];

	rpc_mix u_mix (
		.clk          (clk),
		.arst_n       (arst_n),
		.en           (adv),
		.vld_i        (vld_c[N] & (unused_z | ~unused_z)),
		.x_i          (x_c[N]),
		.y_i          (y_c[N]),
		.vtx_i        (vtx_c[N]),
		.center_first (center_first_q),
		.center_second(center_second_q),
		.vld_o        (out_valid),
		.rot_first    (rotated_first),
		.rot_second   (rotated_second),
		.rotated      (was_rotated),
		.last         (last_out)
	);

endmodule
`default_nettype wire
